>>> design/gsm_pkg.sv
// shared types and constants of the generational slot map
`default_nettype none

package gsm_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned HIDX_W    = 6;
  localparam int unsigned HGEN_W    = 16;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned LIVE_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_DESTROY = 2'd1,
    OP_LOOKUP  = 2'd2
  } gsm_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } gsm_status_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [HIDX_W-1:0] handle_index;
    logic [HGEN_W-1:0] handle_generation;
    logic [DATA_W-1:0] payload_in;
  } gsm_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HIDX_W-1:0]   slot_out;
    logic [HGEN_W-1:0]   generation_out;
    logic [DATA_W-1:0]   payload_out;
    logic [LIVE_W-1:0]   live_count;
  } gsm_rsp_t;

endpackage

`default_nettype wire

>>> design/gsm_if.sv
// request and response channel interfaces of the generational slot map
`default_nettype none

interface gsm_req_if
  import gsm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [HIDX_W-1:0] handle_index;
  logic [HGEN_W-1:0] handle_generation;
  logic [DATA_W-1:0] payload_in;

  modport source (
    output valid, operation, handle_index, handle_generation, payload_in,
    input  ready
  );
  modport sink (
    input  valid, operation, handle_index, handle_generation, payload_in,
    output ready
  );
endinterface

interface gsm_rsp_if
  import gsm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HIDX_W-1:0]   slot_out;
  logic [HGEN_W-1:0]   generation_out;
  logic [DATA_W-1:0]   payload_out;
  logic [LIVE_W-1:0]   live_count;

  modport source (
    output valid, status, slot_out, generation_out, payload_out, live_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot_out, generation_out, payload_out, live_count,
    output ready
  );
endinterface

`default_nettype wire

>>> design/generational_slot_map.sv
// top level of the generational slot map: sequencer core and response register
//
// Slot map with generational handles over a densely packed payload store.
// Add reuses the most recently freed slot or issues a fresh one, appends the
// payload and answers with slot and generation; destroy validates the handle,
// moves the last payload into the hole, repoints the slot that owned it,
// frees the slot and bumps its generation; lookup validates and returns the
// payload. Rejected requests answer stale or full and change nothing. Every
// transaction gives exactly one response. One request is worked on at a time.
// A destroy reads the slot table one entry at a time through its single read
// port while it searches for the owner of the last payload. A registered
// response stage lets the next request in while the previous response waits.
// All state lives in three memories (slot table, payload store, free stack);
// issued-slot and live counts serve as fill marks, so no clearing pass runs
// after reset.
`default_nettype none

module generational_slot_map
  import gsm_pkg::*;
#(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned PAYLOAD_W = 64,
  parameter int unsigned GEN_W     = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gsm_req_if.sink    req_i,
  gsm_rsp_if.source  rsp_o
);

  gsm_req_t core_req;
  gsm_rsp_t core_rsp;
  logic     core_rsp_valid;
  logic     core_rsp_ready;

  // response register
  logic     out_valid_q, out_valid_d;
  gsm_rsp_t out_q, out_d;

  // request fields gathered into one word for the core
  assign core_req = '{
    operation:         req_i.operation,
    handle_index:      req_i.handle_index,
    handle_generation: req_i.handle_generation,
    payload_in:        req_i.payload_in
  };

  gsm_core #(
    .SLOTS     (SLOTS),
    .PAYLOAD_W (PAYLOAD_W),
    .GEN_W     (GEN_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (core_req),
    .rsp_valid_o (core_rsp_valid),
    .rsp_ready_i (core_rsp_ready),
    .rsp_o       (core_rsp)
  );

  // the register takes a new response when empty or being drained this cycle
  assign core_rsp_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (core_rsp_valid && core_rsp_ready) begin
      out_valid_d = 1'b1;
      out_d       = core_rsp;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.slot_out       = out_q.slot_out;
  assign rsp_o.generation_out = out_q.generation_out;
  assign rsp_o.payload_out    = out_q.payload_out;
  assign rsp_o.live_count     = out_q.live_count;

endmodule

`default_nettype wire

>>> design/gsm_core.sv
// sequencer and memories of the generational slot map
`default_nettype none

module gsm_core
  import gsm_pkg::*;
#(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned PAYLOAD_W = 64,
  parameter int unsigned GEN_W     = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire gsm_req_t req_i,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output gsm_rsp_t      rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] pos;
    logic [GEN_W-1:0] gen;
  } slot_ent_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_ADD_POP = 10'b00_0000_0010,
    S_ADD_WR  = 10'b00_0000_0100,
    S_LK_CHK  = 10'b00_0000_1000,
    S_LK_DATA = 10'b00_0001_0000,
    S_DS_CHK  = 10'b00_0010_0000,
    S_DS_MOVE = 10'b00_0100_0000,
    S_DS_SCAN = 10'b00_1000_0000,
    S_DS_FREE = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } state_e;

  // memories
  slot_ent_t            st_mem [SLOTS];
  logic [PAYLOAD_W-1:0] dn_mem [SLOTS];
  logic [IDX_W-1:0]     fs_mem [SLOTS];

  slot_ent_t            st_rdata_q;
  logic [PAYLOAD_W-1:0] dn_rdata_q;
  logic [IDX_W-1:0]     fs_rdata_q;

  logic                 st_we, dn_we, fs_we;
  logic [IDX_W-1:0]     st_waddr, st_raddr, dn_waddr, dn_raddr, fs_waddr, fs_raddr;
  slot_ent_t            st_wdata;
  logic [PAYLOAD_W-1:0] dn_wdata;
  logic [IDX_W-1:0]     fs_wdata;

  // control and working registers
  state_e           state_q, state_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] issued_q, issued_d;
  logic [CNT_W-1:0] dense_q, dense_d;
  gsm_req_t         req_q, req_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             fresh_q, fresh_d;
  logic [IDX_W-1:0] hole_q, hole_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  gsm_rsp_t         res_q, res_d;

  logic             hit;
  logic [IDX_W-1:0] last_pos;
  logic [GEN_W-1:0] add_gen;
  logic [IDX_W-1:0] req_slot;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dn_we) begin
      dn_mem[dn_waddr] <= dn_wdata;
    end
    dn_rdata_q <= dn_mem[dn_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rdata_q <= fs_mem[fs_raddr];
  end

  // handle must be issued, live and of the current generation
  assign hit = (32'(req_q.handle_index) < 32'(issued_q)) && st_rdata_q.valid &&
               (32'(st_rdata_q.gen) == 32'(req_q.handle_generation));
  assign last_pos = IDX_W'(dense_q - 1'b1);
  assign add_gen  = fresh_q ? '0 : st_rdata_q.gen;
  assign req_slot = IDX_W'(req_i.handle_index);

  always_comb begin
    state_d  = state_q;
    free_d   = free_q;
    issued_d = issued_q;
    dense_d  = dense_q;
    req_d    = req_q;
    slot_d   = slot_q;
    fresh_d  = fresh_q;
    hole_d   = hole_q;
    gen_d    = gen_q;
    scan_d   = scan_q;
    res_d    = res_q;

    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
    dn_we = 1'b0; dn_waddr = '0; dn_wdata = '0; dn_raddr = '0;
    fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_raddr = '0;

    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          case (gsm_op_e'(req_i.operation))
            OP_ADD: begin
              if (free_q != '0) begin
                fs_raddr = IDX_W'(free_q - 1'b1);
                state_d  = S_ADD_POP;
              end else if (issued_q < CNT_W'(SLOTS)) begin
                slot_d  = IDX_W'(issued_q);
                fresh_d = 1'b1;
                state_d = S_ADD_WR;
              end else begin
                res_d.status = ST_FULL;
                state_d      = S_RESP;
              end
            end
            OP_DESTROY: begin
              st_raddr = req_slot;
              state_d  = S_DS_CHK;
            end
            OP_LOOKUP: begin
              st_raddr = req_slot;
              state_d  = S_LK_CHK;
            end
            default: begin
              res_d.status = ST_STALE;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      S_ADD_POP: begin
        slot_d   = fs_rdata_q;
        fresh_d  = 1'b0;
        st_raddr = fs_rdata_q;
        free_d   = free_q - 1'b1;
        state_d  = S_ADD_WR;
      end

      S_ADD_WR: begin
        st_we    = 1'b1;
        st_waddr = slot_q;
        st_wdata = '{valid: 1'b1, pos: IDX_W'(dense_q), gen: add_gen};
        dn_we    = 1'b1;
        dn_waddr = IDX_W'(dense_q);
        dn_wdata = PAYLOAD_W'(req_q.payload_in);
        dense_d  = dense_q + 1'b1;
        if (fresh_q) begin
          issued_d = issued_q + 1'b1;
        end
        res_d.status         = ST_OK;
        res_d.slot_out       = HIDX_W'(slot_q);
        res_d.generation_out = HGEN_W'(add_gen);
        state_d              = S_RESP;
      end

      S_LK_CHK: begin
        if (hit) begin
          dn_raddr = st_rdata_q.pos;
          state_d  = S_LK_DATA;
        end else begin
          res_d.status = ST_STALE;
          state_d      = S_RESP;
        end
      end

      S_LK_DATA: begin
        res_d.status      = ST_OK;
        res_d.payload_out = DATA_W'(dn_rdata_q);
        state_d           = S_RESP;
      end

      S_DS_CHK: begin
        if (hit && (dense_q != '0)) begin
          hole_d   = st_rdata_q.pos;
          gen_d    = st_rdata_q.gen;
          dn_raddr = last_pos;
          state_d  = S_DS_MOVE;
        end else begin
          res_d.status = ST_STALE;
          state_d      = S_RESP;
        end
      end

      // last payload fills the hole, then the slot table scan starts
      S_DS_MOVE: begin
        dn_we    = 1'b1;
        dn_waddr = hole_q;
        dn_wdata = dn_rdata_q;
        st_raddr = '0;
        scan_d   = '0;
        state_d  = S_DS_SCAN;
      end

      S_DS_SCAN: begin
        if (st_rdata_q.valid && (st_rdata_q.pos == last_pos)) begin
          st_we    = 1'b1;
          st_waddr = scan_q;
          st_wdata = '{valid: 1'b1, pos: hole_q, gen: st_rdata_q.gen};
          state_d  = S_DS_FREE;
        end else if ((CNT_W'(scan_q) + 1'b1) == issued_q) begin
          state_d = S_DS_FREE;
        end else begin
          st_raddr = scan_q + 1'b1;
          scan_d   = scan_q + 1'b1;
        end
      end

      S_DS_FREE: begin
        st_we    = 1'b1;
        st_waddr = IDX_W'(req_q.handle_index);
        st_wdata = '{valid: 1'b0, pos: '0, gen: GEN_W'(gen_q + 1'b1)};
        fs_we    = 1'b1;
        fs_waddr = IDX_W'(free_q);
        fs_wdata = IDX_W'(req_q.handle_index);
        free_d   = free_q + 1'b1;
        dense_d  = dense_q - 1'b1;
        res_d.status = ST_OK;
        state_d  = S_RESP;
      end

      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_o            = res_q;
    rsp_o.live_count = LIVE_W'(dense_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      free_q   <= '0;
      issued_q <= '0;
      dense_q  <= '0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      issued_q <= issued_d;
      dense_q  <= dense_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    slot_q  <= slot_d;
    fresh_q <= fresh_d;
    hole_q  <= hole_d;
    gen_q   <= gen_d;
    scan_q  <= scan_d;
    res_q   <= res_d;
  end

  // every issued slot is either live or on the free stack, except while a
  // popped slot waits to be written
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ADD_WR) |-> ((32'(free_q) + 32'(dense_q)) == 32'(issued_q)))
    else $error("free and live slots do not add up to issued slots");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DS_SCAN) |-> (32'(scan_q) < 32'(issued_q)))
    else $error("slot scan ran past the issued slots");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) && (res_q.status == ST_FULL) |->
      (free_q == '0) && (issued_q == CNT_W'(SLOTS)))
    else $error("table full reported with slots available");

  a_destroy_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DS_FREE) |=> (dense_q == $past(dense_q) - 1'b1) &&
      (free_q == $past(free_q) + 1'b1))
    else $error("destroy did not pop the dense store and push the slot");

endmodule

`default_nettype wire

>>> bench/slot_map_checker.sv
// checker for the generational slot map: predicts every response and compares it field by field
`default_nettype none

module slot_map_checker
  import gsm_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gsm_req_if          req_i,
  gsm_rsp_if          rsp_i,
  output int unsigned fault_count_o,
  output int unsigned pending_o
);

  // private copy of the slot map
  logic [DATA_W-1:0] payload_bank [SLOTS];
  logic [HIDX_W-1:0] slot_pos     [SLOTS];
  logic              slot_live    [SLOTS];
  logic [HGEN_W-1:0] slot_gen     [SLOTS];
  logic [HIDX_W-1:0] freed_slots  [SLOTS];
  logic [LIVE_W-1:0] freed_depth;
  logic [LIVE_W-1:0] issued_cnt;
  logic [LIVE_W-1:0] live_cnt;

  gsm_rsp_t expected_rsp [$];

  initial begin
    fault_count_o = 0;
    pending_o     = 0;
  end

  function automatic void clear_map();
    int s;
    for (s = 0; s < SLOTS; s++) begin
      payload_bank[s] = '0;
      slot_pos[s]     = '0;
      slot_live[s]    = 1'b0;
      slot_gen[s]     = '0;
      freed_slots[s]  = '0;
    end
    freed_depth = '0;
    issued_cnt  = '0;
    live_cnt    = '0;
  endfunction

  function automatic logic handle_good(input logic [HIDX_W-1:0] idx,
                                       input logic [HGEN_W-1:0] gen);
    return ({1'b0, idx} < issued_cnt) && slot_live[idx] && (slot_gen[idx] == gen);
  endfunction

  // applies one request to the private map and returns the response it owes
  function automatic gsm_rsp_t apply_request(input gsm_req_t r);
    gsm_rsp_t          rsp;
    logic [HIDX_W-1:0] slot;
    logic [HIDX_W-1:0] hole;
    logic [HIDX_W-1:0] last;
    logic              have;
    logic              found;
    int                s;
    rsp        = '0;
    rsp.status = ST_OK;
    case (r.operation)
      OP_ADD: begin
        have = 1'b1;
        slot = '0;
        if (freed_depth != 0) begin
          freed_depth = freed_depth - 1'b1;
          slot        = freed_slots[freed_depth[HIDX_W-1:0]];
        end else if (issued_cnt < SLOTS) begin
          slot       = issued_cnt[HIDX_W-1:0];
          issued_cnt = issued_cnt + 1'b1;
        end else begin
          have = 1'b0;
        end
        if (!have || live_cnt >= SLOTS) begin
          rsp.status = ST_FULL;
        end else begin
          payload_bank[live_cnt[HIDX_W-1:0]] = r.payload_in;
          slot_pos[slot]     = live_cnt[HIDX_W-1:0];
          slot_live[slot]    = 1'b1;
          live_cnt           = live_cnt + 1'b1;
          rsp.slot_out       = slot;
          rsp.generation_out = slot_gen[slot];
        end
      end
      OP_DESTROY: begin
        if (!handle_good(r.handle_index, r.handle_generation) || live_cnt == 0) begin
          rsp.status = ST_STALE;
        end else begin
          // swap and pop: the last payload fills the hole, its owner is repointed
          hole = slot_pos[r.handle_index];
          last = live_cnt[HIDX_W-1:0] - 1'b1;
          payload_bank[hole] = payload_bank[last];
          found = 1'b0;
          for (s = 0; s < issued_cnt; s++) begin
            if (!found && slot_live[s] && slot_pos[s] == last) begin
              slot_pos[s] = hole;
              found       = 1'b1;
            end
          end
          slot_live[r.handle_index] = 1'b0;
          slot_pos[r.handle_index]  = '0;
          if (freed_depth < SLOTS) begin
            freed_slots[freed_depth[HIDX_W-1:0]] = r.handle_index;
            freed_depth = freed_depth + 1'b1;
          end
          slot_gen[r.handle_index] = slot_gen[r.handle_index] + 1'b1;
          live_cnt = live_cnt - 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (!handle_good(r.handle_index, r.handle_generation)) begin
          rsp.status = ST_STALE;
        end else begin
          rsp.payload_out = payload_bank[slot_pos[r.handle_index]];
        end
      end
      default: begin
        rsp.status = ST_STALE;
      end
    endcase
    rsp.live_count = live_cnt;
    return rsp;
  endfunction

  task automatic report_fault(input string what);
    fault_count_o++;
    $display("[%0t] slot map: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : watch
    gsm_req_t req;
    gsm_rsp_t got;
    gsm_rsp_t want;
    if (!rst_ni) begin
      clear_map();
      expected_rsp.delete();
    end else begin
      // responses first: a response never belongs to a request taken at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        got.status         = rsp_i.status;
        got.slot_out       = rsp_i.slot_out;
        got.generation_out = rsp_i.generation_out;
        got.payload_out    = rsp_i.payload_out;
        got.live_count     = rsp_i.live_count;
        if (expected_rsp.size() == 0) begin
          report_fault("response with no request outstanding");
        end else begin
          want = expected_rsp.pop_front();
          check_field("status", DATA_W'(got.status), DATA_W'(want.status));
          check_field("slot_out", DATA_W'(got.slot_out), DATA_W'(want.slot_out));
          check_field("generation_out", DATA_W'(got.generation_out),
                      DATA_W'(want.generation_out));
          check_field("payload_out", got.payload_out, want.payload_out);
          check_field("live_count", DATA_W'(got.live_count), DATA_W'(want.live_count));
        end
      end
      if (req_i.valid && req_i.ready) begin
        req.operation         = req_i.operation;
        req.handle_index      = req_i.handle_index;
        req.handle_generation = req_i.handle_generation;
        req.payload_in        = req_i.payload_in;
        expected_rsp = {expected_rsp, apply_request(req)};
      end
    end
    pending_o = expected_rsp.size();
  end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench top of the generational slot map: stimulus, response stalls and verdict
`default_nettype none

module testbench
  import gsm_pkg::*;
();

  localparam int unsigned SLOTS        = 64;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // idle time after the last expected response, to catch a stray late one
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned DEAD_KEEP    = 32;

  // the encoding left unused by the operation field
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [HIDX_W-1:0] idx;
    logic [HGEN_W-1:0] gen;
  } handle_t;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  typedef enum int unsigned {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fault_count;
  int unsigned pending_rsp;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned issued_items = 0;
  int unsigned ready_run    = 0;
  ready_mode_e ready_mode   = RDY_ALWAYS;

  // handles the block has handed out and not yet seen destroyed, and recent dead ones
  handle_t         live_handles [$];
  handle_t         dead_handles [$];
  // operations of transactions whose response has not come back yet
  logic [OP_W-1:0] ops_in_flight [$];

  gsm_req_if req_if ();
  gsm_rsp_if rsp_if ();

  generational_slot_map #(
    .SLOTS     (SLOTS),
    .PAYLOAD_W (DATA_W),
    .GEN_W     (HGEN_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  slot_map_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .fault_count_o (fault_count),
    .pending_o     (pending_rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // response side stalls on a pattern that changes after each run of random length,
  // including stretches where it never stalls at all
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_run  = $urandom_range(16, 160);
    end
    ready_run = ready_run - 1;
    case (ready_mode)
      RDY_ALWAYS: rsp_if.ready <= 1'b1;
      RDY_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default:    rsp_if.ready <= (ready_run % 12 == 0);
    endcase
  end

  // collect the handles of successful adds; sampled at the falling edge, where
  // valid and ready already show the transaction that the next rising edge
  // completes, so the stimulus at that edge sees the pool in a settled state
  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready && ops_in_flight.size() != 0) begin
      if (ops_in_flight.pop_front() == OP_ADD && rsp_if.status == ST_OK) begin
        live_handles = {live_handles, handle_t'({rsp_if.slot_out, rsp_if.generation_out})};
      end
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      ops_in_flight = {ops_in_flight, req_if.operation};
    end
  end

  function automatic gsm_req_t make_request(input logic [OP_W-1:0] op,
                                            input logic [HIDX_W-1:0] idx,
                                            input logic [HGEN_W-1:0] gen,
                                            input logic [DATA_W-1:0] data);
    gsm_req_t r;
    r.operation         = op;
    r.handle_index      = idx;
    r.handle_generation = gen;
    r.payload_in        = data;
    return r;
  endfunction

  // a destroyed handle leaves the live pool and is kept for stale requests
  function automatic void retire_handle(input handle_t h);
    int k;
    for (k = live_handles.size() - 1; k >= 0; k--) begin
      if (live_handles[k] == h) begin
        live_handles.delete(k);
      end
    end
    dead_handles = {dead_handles, h};
    if (dead_handles.size() > DEAD_KEEP) begin
      void'(dead_handles.pop_front());
    end
  endfunction

  // presents one transaction and returns at the edge that takes it; the sender
  // runs in bursts of random length with random idle gaps between them
  task automatic push_request(input gsm_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left = burst_left - 1;
    req_if.valid             <= 1'b1;
    req_if.operation         <= r.operation;
    req_if.handle_index      <= r.handle_index;
    req_if.handle_generation <= r.handle_generation;
    req_if.payload_in        <= r.payload_in;
    do @(posedge clk_i); while (!req_if.ready);
    issued_items++;
  endtask

  // one random transaction: mostly live handles, some stale or never issued
  // ones, and now and then the unused operation code
  task automatic send_mix(input int unsigned add_w, input int unsigned destroy_w,
                          input int unsigned lookup_w);
    gsm_req_t    r;
    handle_t     h;
    int unsigned pick;
    int unsigned k;
    r = make_request(OP_ADD, HIDX_W'($urandom_range(0, SLOTS - 1)),
                     HGEN_W'($urandom_range(0, 65535)), {$urandom, $urandom});
    h = {r.handle_index, r.handle_generation};
    pick = $urandom_range(0, add_w + destroy_w + lookup_w - 1);
    if (pick < add_w) begin
      r.operation = OP_ADD;
    end else if (pick < add_w + destroy_w) begin
      r.operation = OP_DESTROY;
    end else begin
      r.operation = OP_LOOKUP;
    end
    if (r.operation != OP_ADD) begin
      pick = $urandom_range(0, 99);
      if (pick < 75 && live_handles.size() != 0) begin
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        if (r.operation == OP_DESTROY) begin
          retire_handle(h);
        end
      end else if (pick < 90 && dead_handles.size() != 0) begin
        // old generation, or the generation the freed slot carries now
        h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
        h.gen = h.gen + HGEN_W'($urandom_range(0, 1));
      end else if (pick < 96) begin
        if ($urandom_range(0, 1) == 0) begin
          h.gen = HGEN_W'($urandom_range(0, 3));
        end
      end else begin
        r.operation = OP_UNUSED;
      end
      r.handle_index      = h.idx;
      r.handle_generation = h.gen;
    end
    push_request(r);
  endtask

  initial begin : stimulus
    int unsigned first_random;
    int unsigned n;
    phase_e      phase;

    req_if.valid             = 1'b0;
    req_if.operation         = OP_ADD;
    req_if.handle_index      = '0;
    req_if.handle_generation = '0;
    req_if.payload_in        = '0;
    rsp_if.ready             = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; after reset slots are issued in order from zero
    push_request(make_request(OP_ADD, '0, '0, '0));
    push_request(make_request(OP_ADD, '1, '1, '1));
    push_request(make_request(OP_ADD, '0, '0, {$urandom, $urandom}));
    push_request(make_request(OP_LOOKUP, 6'd0, 16'd0, '1));
    push_request(make_request(OP_LOOKUP, 6'd1, 16'd0, '0));
    // wrong generation, never issued slot, first index past the issued ones
    push_request(make_request(OP_LOOKUP, 6'd1, 16'hFFFF, '0));
    push_request(make_request(OP_LOOKUP, 6'd63, 16'd0, '0));
    push_request(make_request(OP_DESTROY, 6'd3, 16'd0, '0));
    // destroy from the front: the last payload moves into the hole
    push_request(make_request(OP_DESTROY, 6'd0, 16'd0, '0));
    retire_handle({6'd0, 16'd0});
    push_request(make_request(OP_LOOKUP, 6'd2, 16'd0, '0));
    // freed slot asked for with the generation it now carries: the valid bit refuses it
    push_request(make_request(OP_LOOKUP, 6'd0, 16'd1, '0));
    push_request(make_request(OP_DESTROY, 6'd0, 16'd0, '0));
    // freed slot comes back with its generation bumped
    push_request(make_request(OP_ADD, '1, '0, {$urandom, $urandom}));
    push_request(make_request(OP_LOOKUP, 6'd0, 16'd1, '0));
    push_request(make_request(OP_UNUSED, 6'($urandom), 16'($urandom), {$urandom, $urandom}));
    push_request(make_request(OP_DESTROY, 6'd2, 16'd0, '0));
    retire_handle({6'd2, 16'd0});
    push_request(make_request(OP_LOOKUP, 6'd0, 16'd1, '0));
    push_request(make_request(OP_DESTROY, 6'd0, 16'd1, '0));
    retire_handle({6'd0, 16'd1});
    // destroy of the very last entry empties the store
    push_request(make_request(OP_DESTROY, 6'd1, 16'd0, '0));
    retire_handle({6'd1, 16'd0});
    push_request(make_request(OP_LOOKUP, 6'd1, 16'd0, '0));
    push_request(make_request(OP_ADD, 6'd63, 16'hFFFF, 64'h8000_0000_0000_0001));
    push_request(make_request(OP_UNUSED, 6'd63, 16'hFFFF, '1));
    push_request(make_request(OP_DESTROY, 6'd63, 16'hFFFF, '0));

    // random part in phases: filling past full, draining, and a busy mix
    first_random = issued_items;
    while (issued_items - first_random < RANDOM_ITEMS) begin
      phase = phase_e'($urandom_range(0, 2));
      case (phase)
        PH_FILL: begin
          // the pool can hold handles that went stale behind its back
          if (live_handles.size() < SLOTS + 6) begin
            n = SLOTS + 6 - live_handles.size();
          end else begin
            n = 6;
          end
          repeat (n) send_mix(90, 0, 10);
        end
        PH_DRAIN: begin
          n = live_handles.size() + 4;
          repeat (n) send_mix(0, 85, 15);
        end
        default: begin
          repeat ($urandom_range(20, 80)) send_mix(40, 30, 30);
        end
      endcase
    end
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_rsp != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/gsm_pkg.sv
design/gsm_if.sv
design/gsm_core.sv
design/generational_slot_map.sv
bench/slot_map_checker.sv
bench/testbench.sv
